@@ rtl/lru_page_replacement_top_macros.svh @@
// assertion macros shared by the lru page replacement checker
// expects clk and rst_n in the scope of use
`ifndef LRU_PAGE_REPLACEMENT_TOP_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_TOP_MACROS_SVH

// same-cycle implication
`define LRUPR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LRUPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lrupr_pkg.sv @@
// shared types and constants of the lru page replacement block
// no dependencies
`timescale 1ns / 1ps

package lrupr_pkg;

  localparam int PAGE_W      = 16;
  localparam int FAULT_CNT_W = 32;
  localparam int FRAME_IDX_W = 4;
  localparam int CFG_W       = 5;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  localparam logic [CFG_W-1:0]       FRAMES_IN_USE_RST = 5'd16;
  localparam logic [0:0]             REG_FRAMES_IN_USE = 1'b0;
  localparam logic [FAULT_CNT_W-1:0] FAULT_CNT_MAX     = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_PUSH
  } seq_state_t;

  typedef struct packed {
    logic start;
    logic rd_en;
    logic upd;
    logic decide;
    logic push;
  } seq_ctrl_t;

endpackage

@@ rtl/lru_page_replacement_top.sv @@
// lru page replacement top level: config register, frame ram, sequencer, evaluator, output register
// one request runs as a scan pass and then a write-back pass over the n frames in use (1..FRAMES),
// then one push into the output register, which waits while a stalled result still occupies it
// a new request is taken while a result waits
// synchronous active-low reset clears control state, fault count and fill count; no clear pass
`timescale 1ns / 1ps

module lru_page_replacement_top #(
  parameter int FRAMES = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lrupr_pkg::PAGE_W-1:0]        in_page_number,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_fault,
  output logic [lrupr_pkg::FRAME_IDX_W-1:0]   out_frame_index,
  output logic [lrupr_pkg::FAULT_CNT_W-1:0]   out_fault_count,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lrupr_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [lrupr_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [lrupr_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready
);

  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);
  localparam int EW = lrupr_pkg::PAGE_W + IW;
  localparam int DW = lrupr_pkg::APB_DATA_W;
  localparam int AW = lrupr_pkg::APB_ADDR_W;
  localparam int XW = lrupr_pkg::FRAME_IDX_W;
  localparam int FW = lrupr_pkg::FAULT_CNT_W;
  localparam int GW = lrupr_pkg::CFG_W;

  logic [GW-1:0] frames_in_use_r;
  logic          cfg_wr;
  logic          reg_sel;
  logic [CW-1:0] n_act;
  logic [CW-1:0] n_cur;

  lrupr_pkg::seq_ctrl_t ctrl;
  logic [IW-1:0] rd_addr;
  logic [EW-1:0] rdata;
  logic          we;
  logic [IW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic          res_fault;
  logic [IW-1:0] res_slot;
  logic [FW-1:0] res_count;

  logic          out_valid_r, out_valid_nxt;
  logic          out_fault_r;
  logic [XW-1:0] out_frame_index_r;
  logic [FW-1:0] out_fault_count_r;
  logic          out_free;

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = (paddr[AW-1:2] == lrupr_pkg::REG_FRAMES_IN_USE);
  assign cfg_wr  = psel && penable && pwrite && reg_sel;
  assign prdata  = reg_sel ? DW'(frames_in_use_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= lrupr_pkg::FRAMES_IN_USE_RST;
    end else if (cfg_wr) begin
      frames_in_use_r <= pwdata[GW-1:0];
    end
  end

  always_comb begin
    if (frames_in_use_r == '0) begin
      n_act = CW'(1);
    end else if (int'(frames_in_use_r) > FRAMES) begin
      n_act = CW'(FRAMES);
    end else begin
      n_act = CW'(frames_in_use_r);
    end
  end

  lrupr_seq #(
    .FRAMES(FRAMES)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .n_act    (n_act),
    .out_free (out_free),
    .ctrl     (ctrl),
    .rd_addr  (rd_addr),
    .n_cur    (n_cur)
  );

  lrupr_ram #(
    .WIDTH(EW),
    .DEPTH(FRAMES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ctrl.rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  lrupr_eval #(
    .FRAMES(FRAMES)
  ) u_eval (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .in_page_number (in_page_number),
    .rd_addr        (rd_addr),
    .n_cur          (n_cur),
    .rdata          (rdata),
    .we             (we),
    .waddr          (waddr),
    .wdata          (wdata),
    .res_fault      (res_fault),
    .res_slot       (res_slot),
    .res_count      (res_count)
  );

  // output register
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.push) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      out_fault_r       <= res_fault;
      out_frame_index_r <= XW'(res_slot);
      out_fault_count_r <= res_count;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_fault       = out_fault_r;
  assign out_frame_index = out_frame_index_r;
  assign out_fault_count = out_fault_count_r;

endmodule

@@ rtl/lrupr_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module lrupr_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/lrupr_seq.sv @@
// sequencer: request intake, scan and write-back passes over the frame ram
// depends on lrupr_pkg
`timescale 1ns / 1ps

module lrupr_seq #(
  parameter int FRAMES = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic [$clog2(FRAMES+1)-1:0]               n_act,
  input  logic                                      out_free,
  output lrupr_pkg::seq_ctrl_t                      ctrl,
  output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] rd_addr,
  output logic [$clog2(FRAMES+1)-1:0]               n_cur
);

  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);

  lrupr_pkg::seq_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] n_r;
  logic          beat_r;
  logic          pass_done;

  assign pass_done = (cnt_r == n_r) && !beat_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lrupr_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = lrupr_pkg::ST_SCAN;
      end
      lrupr_pkg::ST_SCAN: begin
        if (pass_done) state_nxt = lrupr_pkg::ST_UPDATE;
      end
      lrupr_pkg::ST_UPDATE: begin
        if (pass_done) state_nxt = lrupr_pkg::ST_PUSH;
      end
      lrupr_pkg::ST_PUSH: begin
        if (out_free) state_nxt = lrupr_pkg::ST_IDLE;
      end
      default: state_nxt = lrupr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl     = '0;
    in_stall = 1'b1;
    unique case (state_r)
      lrupr_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        ctrl.start = in_valid;
      end
      lrupr_pkg::ST_SCAN: begin
        ctrl.rd_en  = (cnt_r != n_r);
        ctrl.decide = pass_done;
      end
      lrupr_pkg::ST_UPDATE: begin
        ctrl.rd_en = (cnt_r != n_r);
        ctrl.upd   = 1'b1;
      end
      lrupr_pkg::ST_PUSH: begin
        ctrl.push = out_free;
      end
      default: ctrl = '0;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.start || ctrl.decide) begin
      cnt_nxt = '0;
    end else if (ctrl.rd_en) begin
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrupr_pkg::ST_IDLE;
      cnt_r   <= '0;
      beat_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      beat_r  <= ctrl.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      n_r <= n_act;
    end
  end

  assign rd_addr = cnt_r[IW-1:0];
  assign n_cur   = n_r;

endmodule

@@ rtl/lrupr_eval.sv @@
// frame evaluation: hit search, victim choice, recency aging and write-back
// depends on lrupr_pkg; reads and writes the frame ram through the top level
`timescale 1ns / 1ps

module lrupr_eval #(
  parameter int FRAMES = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  lrupr_pkg::seq_ctrl_t                      ctrl,
  input  logic [lrupr_pkg::PAGE_W-1:0]              in_page_number,
  input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] rd_addr,
  input  logic [$clog2(FRAMES+1)-1:0]               n_cur,
  input  logic [lrupr_pkg::PAGE_W+((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] rdata,
  output logic                                      we,
  output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] waddr,
  output logic [lrupr_pkg::PAGE_W+((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] wdata,
  output logic                                      res_fault,
  output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] res_slot,
  output logic [lrupr_pkg::FAULT_CNT_W-1:0]         res_count
);

  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);
  localparam int PW = lrupr_pkg::PAGE_W;
  localparam int FW = lrupr_pkg::FAULT_CNT_W;
  localparam logic [IW-1:0] RANK_MAX = IW'(FRAMES - 1);

  logic [PW-1:0] page_r;
  logic          beat_vld_r, beat_upd_r;
  logic [IW-1:0] beat_idx_r;
  logic          hit_r, hit_nxt;
  logic [IW-1:0] hit_slot_r, hit_slot_nxt;
  logic [IW-1:0] hit_rank_r, hit_rank_nxt;
  logic [IW-1:0] vic_slot_r, vic_slot_nxt;
  logic [IW-1:0] vic_rank_r, vic_rank_nxt;
  logic [CW-1:0] filled_r, filled_nxt;
  logic [FW-1:0] faults_r, faults_nxt;
  logic          fault_r, fault_nxt;
  logic [IW-1:0] slot_r, slot_nxt;
  logic [IW-1:0] old_rank_r, old_rank_nxt;
  logic          age_all_r, age_all_nxt;

  logic [PW-1:0] d_page;
  logic [IW-1:0] d_rank;
  logic [IW-1:0] rank_inc;
  logic          in_filled;
  logic          scan_beat;

  assign d_page    = rdata[PW+IW-1:IW];
  assign d_rank    = rdata[IW-1:0];
  assign rank_inc  = d_rank + IW'(1);
  assign in_filled = CW'(beat_idx_r) < filled_r;
  assign scan_beat = beat_vld_r && !beat_upd_r;

  // scan accumulators
  always_comb begin
    hit_nxt      = hit_r;
    hit_slot_nxt = hit_slot_r;
    hit_rank_nxt = hit_rank_r;
    vic_slot_nxt = vic_slot_r;
    vic_rank_nxt = vic_rank_r;
    if (ctrl.start) begin
      hit_nxt      = 1'b0;
      vic_slot_nxt = '0;
      vic_rank_nxt = '0;
    end else if (scan_beat) begin
      if (in_filled && (d_page == page_r) && !hit_r) begin
        hit_nxt      = 1'b1;
        hit_slot_nxt = beat_idx_r;
        hit_rank_nxt = d_rank;
      end
      if (in_filled && (d_rank > vic_rank_r)) begin
        vic_slot_nxt = beat_idx_r;
        vic_rank_nxt = d_rank;
      end
    end
  end

  // replacement decision
  always_comb begin
    fault_nxt    = fault_r;
    slot_nxt     = slot_r;
    old_rank_nxt = old_rank_r;
    age_all_nxt  = age_all_r;
    filled_nxt   = filled_r;
    faults_nxt   = faults_r;
    if (ctrl.decide) begin
      fault_nxt = !hit_r;
      if (hit_r) begin
        slot_nxt     = hit_slot_r;
        old_rank_nxt = hit_rank_r;
        age_all_nxt  = 1'b0;
      end else begin
        age_all_nxt = 1'b1;
        if (faults_r != lrupr_pkg::FAULT_CNT_MAX) begin
          faults_nxt = faults_r + FW'(1);
        end
        if (filled_r < n_cur) begin
          slot_nxt   = filled_r[IW-1:0];
          filled_nxt = filled_r + CW'(1);
        end else begin
          slot_nxt = vic_slot_r;
        end
      end
    end
  end

  // write-back of every scanned entry: the chosen slot gets rank 0, the other entries are aged or kept
  always_comb begin
    we    = beat_vld_r && beat_upd_r;
    waddr = beat_idx_r;
    wdata = rdata;
    if (beat_idx_r == slot_r) begin
      wdata = {(fault_r ? page_r : d_page), IW'(0)};
    end else if (in_filled && (age_all_r || (d_rank < old_rank_r)) &&
                 (d_rank != RANK_MAX)) begin
      wdata = {d_page, rank_inc};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_vld_r <= 1'b0;
      hit_r      <= 1'b0;
      filled_r   <= '0;
      faults_r   <= '0;
      fault_r    <= 1'b0;
      age_all_r  <= 1'b0;
    end else begin
      beat_vld_r <= ctrl.rd_en;
      hit_r      <= hit_nxt;
      filled_r   <= filled_nxt;
      faults_r   <= faults_nxt;
      fault_r    <= fault_nxt;
      age_all_r  <= age_all_nxt;
    end
  end

  always_ff @(posedge clk) begin
    beat_upd_r <= ctrl.upd;
    beat_idx_r <= rd_addr;
    hit_slot_r <= hit_slot_nxt;
    hit_rank_r <= hit_rank_nxt;
    vic_slot_r <= vic_slot_nxt;
    vic_rank_r <= vic_rank_nxt;
    slot_r     <= slot_nxt;
    old_rank_r <= old_rank_nxt;
    if (ctrl.start) begin
      page_r <= in_page_number;
    end
  end

  assign res_fault = fault_r;
  assign res_slot  = slot_r;
  assign res_count = faults_r;

endmodule

@@ rtl/lrupr_chk.sv @@
// port-level checker for the lru page replacement top level, bound to it below
// depends on lrupr_pkg and lru_page_replacement_top_macros.svh
`timescale 1ns / 1ps
`include "lru_page_replacement_top_macros.svh"

module lrupr_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              out_fault,
  input logic [lrupr_pkg::FRAME_IDX_W-1:0] out_frame_index,
  input logic [lrupr_pkg::FAULT_CNT_W-1:0] out_fault_count
);

  localparam int FW = lrupr_pkg::FAULT_CNT_W;

  logic [FW-1:0] last_cnt_r;
  logic [FW-1:0] exp_cnt;
  logic          out_take;

  assign out_take = out_valid && !out_stall;
  assign exp_cnt  = (last_cnt_r == lrupr_pkg::FAULT_CNT_MAX) ? last_cnt_r :
                    last_cnt_r + FW'(1);

  // count carried by the last delivered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_cnt_r <= '0;
    end else if (out_take) begin
      last_cnt_r <= out_fault_count;
    end
  end

  `LRUPR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_fault) && $stable(out_frame_index) && $stable(out_fault_count), "stalled result changed")
  `LRUPR_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall, "request taken while busy")
  `LRUPR_ASSERT_SAME(a_hit_count, out_take && !out_fault, out_fault_count == last_cnt_r, "hit moved fault count")
  `LRUPR_ASSERT_SAME(a_fault_count, out_take && out_fault, out_fault_count == exp_cnt, "fault count step wrong")

endmodule

bind lru_page_replacement_top lrupr_chk u_lrupr_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_fault       (out_fault),
  .out_frame_index (out_frame_index),
  .out_fault_count (out_fault_count)
);
